@@ hw/rtl/wbss_pkg.sv @@
// Shared types and constants for the wildcard byte signature scanner.
// Holds the channel payload structs, the internal operation format and codes.
// No dependencies.
package wbss_pkg;

  localparam int SIG_MAX_DEF = 64;
  localparam int OPQ_DEPTH   = 4;
  localparam int OUTQ_DEPTH  = 4;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_SIG_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE    = 1'b1;

  localparam logic [1:0] MODE_LOAD    = 2'd0;
  localparam logic [1:0] MODE_SCAN    = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_SCAN,
    OP_RESTART
  } op_kind_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [5:0] entry_index;
    logic [7:0] entry_byte;
    logic       entry_wildcard;
    logic [7:0] data_byte;
    logic       region_end;
  } in_t;

  typedef struct packed {
    logic        found;
    logic [31:0] match_offset;
    logic [63:0] match_address;
  } out_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [5:0] idx;
    logic [7:0] value;
    logic       flag;
  } op_t;

endpackage

@@ hw/rtl/wbss_fifo.sv @@
// Small synchronous FIFO used for the operation queue and the result queue.
// Depends on wbss_pkg for its default sizes.
module wbss_fifo
  import wbss_pkg::*;
#(
  parameter int WIDTH = $bits(op_t),
  parameter int DEPTH = OPQ_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [WIDTH-1:0]             push_data,
  input  logic                         pop,
  output logic [WIDTH-1:0]             pop_data,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = mem_r[rd_ptr_r];
  assign count    = count_r;

endmodule

@@ hw/rtl/wbss_front.sv @@
// Front end of the scanner: accepts input beats, decodes the mode and queues operations.
// Depends on wbss_pkg and wbss_fifo.
module wbss_front
  import wbss_pkg::*;
#(
  parameter int SIGNATURE_MAX = SIG_MAX_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic q_valid,
  output op_t  q_data,
  input  logic q_pop
);

  localparam int QCW = $clog2(OPQ_DEPTH+1);

  logic           keep;
  logic           push;
  op_t            op;
  logic [QCW-1:0] q_count;

  always_comb begin
    keep     = 1'b0;
    op.kind  = OP_SCAN;
    op.idx   = in_data.entry_index;
    op.value = in_data.data_byte;
    op.flag  = in_data.region_end;
    case (in_data.mode)
      MODE_LOAD: begin
        keep     = (32'(in_data.entry_index) < 32'(SIGNATURE_MAX));
        op.kind  = OP_LOAD;
        op.value = in_data.entry_byte;
        op.flag  = in_data.entry_wildcard;
      end
      MODE_SCAN: begin
        keep = 1'b1;
      end
      MODE_RESTART: begin
        keep    = 1'b1;
        op.kind = OP_RESTART;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready = (q_count != QCW'(OPQ_DEPTH));
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (q_count != '0);

  wbss_fifo #(
    .WIDTH ($bits(op_t)),
    .DEPTH (OPQ_DEPTH)
  ) u_opq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (op),
    .pop       (q_pop),
    .pop_data  (q_data),
    .count     (q_count)
  );

endmodule

@@ hw/rtl/wbss_back.sv @@
// Back end of the scanner: byte history, signature cells, window compare and result build.
// Holds the configuration registers. Depends on wbss_pkg.
module wbss_back
  import wbss_pkg::*;
#(
  parameter int SIGNATURE_MAX = SIG_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [CFG_IDX_W-1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0]           cfg_wdata,
  input  logic                            q_valid,
  input  op_t                             q_data,
  output logic                            q_pop,
  input  logic [$clog2(OUTQ_DEPTH+1)-1:0] out_count,
  output logic                            res_push,
  output out_t                            res_data
);

  localparam int LEN_W = $clog2(SIGNATURE_MAX+1);
  localparam int WIN_W = SIGNATURE_MAX * 8;

  typedef struct packed {
    logic        valid;
    op_t         op;
    logic [31:0] cnt;
  } stg1_t;

  typedef struct packed {
    logic        valid;
    op_t         op;
    logic        ge;
    logic [31:0] off;
  } stg2_t;

  logic [6:0]       sig_len_r;
  logic [63:0]      base_r;
  logic [7:0]       hist_r [SIGNATURE_MAX];
  logic [7:0]       sig_byte_r [SIGNATURE_MAX];
  logic             sig_wild_r [SIGNATURE_MAX];
  logic [WIN_W-1:0] rev_flat;
  logic [WIN_W-1:0] win_r, win_nxt;
  logic [31:0]      cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  stg1_t            s1_r, s1_nxt;
  stg2_t            s2_r, s2_nxt;
  logic [LEN_W-1:0] len_eff;
  logic [LEN_W-1:0] shamt;
  logic [SIGNATURE_MAX-1:0] pos_ok;
  logic             hit;
  logic [63:0]      addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sig_len_r <= '0;
      base_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SIG_LEN: sig_len_r <= cfg_wdata[6:0];
        CFG_BASE:    base_r    <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  assign len_eff = (32'(sig_len_r) > 32'(SIGNATURE_MAX)) ? LEN_W'(SIGNATURE_MAX)
                                                         : LEN_W'(sig_len_r);
  assign shamt   = LEN_W'(SIGNATURE_MAX) - len_eff;

  assign q_pop = q_valid &&
                 ((32'(out_count) + 32'(s1_r.valid) + 32'(s2_r.valid)) < 32'(OUTQ_DEPTH));

  // Issue stage: history shift and byte count.
  always_comb begin
    cnt_nxt = cnt_r;
    if (q_pop) begin
      case (q_data.kind)
        OP_SCAN: begin
          if (cnt_r != '1) begin
            cnt_nxt = cnt_r + 32'd1;
          end
        end
        OP_RESTART: cnt_nxt = '0;
        default:    ;
      endcase
    end
    s1_nxt.valid = q_pop;
    s1_nxt.op    = q_data;
    s1_nxt.cnt   = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (q_pop && (q_data.kind == OP_SCAN)) begin
      hist_r[0] <= q_data.value;
      for (int k = 1; k < SIGNATURE_MAX; k++) begin
        hist_r[k] <= hist_r[k-1];
      end
    end
  end

  // Align stage: the newest len bytes are lined up against signature positions.
  always_comb begin
    for (int j = 0; j < SIGNATURE_MAX; j++) begin
      rev_flat[j*8 +: 8] = hist_r[SIGNATURE_MAX-1-j];
    end
    win_nxt = rev_flat >> {shamt, 3'b000};
    s2_nxt.valid = s1_r.valid;
    s2_nxt.op    = s1_r.op;
    s2_nxt.ge    = (s1_r.cnt >= 32'(len_eff));
    s2_nxt.off   = s1_r.cnt - 32'(len_eff);
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

  // Compare stage.
  always_comb begin
    for (int i = 0; i < SIGNATURE_MAX; i++) begin
      pos_ok[i] = (32'(i) >= 32'(len_eff)) || sig_wild_r[i] ||
                  (sig_byte_r[i] == win_r[i*8 +: 8]);
    end
  end

  assign hit  = (&pos_ok) && (len_eff != '0) && (base_r != '0) && s2_r.ge;
  assign addr = base_r + {32'b0, s2_r.off};

  always_comb begin
    res_push = 1'b0;
    res_data = '0;
    done_nxt = done_r;
    if (s2_r.valid) begin
      case (s2_r.op.kind)
        OP_SCAN: begin
          if (!done_r) begin
            if (hit) begin
              res_push               = 1'b1;
              res_data.found         = 1'b1;
              res_data.match_offset  = s2_r.off;
              res_data.match_address = addr;
              done_nxt               = 1'b1;
            end else if (s2_r.op.flag) begin
              res_push = 1'b1;
              done_nxt = 1'b1;
            end
          end
        end
        OP_RESTART: done_nxt = 1'b0;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s2_r.valid && (s2_r.op.kind == OP_LOAD)) begin
      for (int i = 0; i < SIGNATURE_MAX; i++) begin
        if (32'(s2_r.op.idx) == 32'(i)) begin
          sig_byte_r[i] <= s2_r.op.value;
          sig_wild_r[i] <= s2_r.op.flag;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      done_r     <= 1'b0;
      s1_r.valid <= 1'b0;
      s2_r.valid <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
      s1_r   <= s1_nxt;
      s2_r   <= s2_nxt;
    end
  end

endmodule

@@ hw/rtl/wildcard_byte_signature_scanner_unit.sv @@
// Top level of the wildcard byte signature scanner.
// Depends on wbss_pkg, wbss_fifo, wbss_front and wbss_back.
//
// Usage: write signature_length (index 0) and region_base (index 1) on the cfg_ port.
// Input beats carry a mode: load a signature entry, scan one data byte, or restart.
// Load signature entries, restart, then stream the region's bytes one per beat with
// region_end on the last. At most one result beat per region: a match (found, offset,
// address) or, at region end, a not found beat with zero offset and address.
// Throughput is one input beat per cycle while in_ready is high; every position is
// compared in parallel against the aligned byte history, so there is no per-byte loop.
// An accepted input beat passes in order through the operation queue and the issue,
// align and compare stages; a result beat it causes then enters the result queue.
// When the receiver stalls, results wait in a four-entry result queue; issue from the
// operation queue stops once the result queue could overflow, the operation queue
// fills and in_ready drops. Inputs are still accepted while a result waits.
// Reset clears both queues, the byte count, the scan state and the registers; the
// signature cells keep no reset value and must be loaded before use.
module wildcard_byte_signature_scanner_unit
  import wbss_pkg::*;
#(
  parameter int SIGNATURE_MAX = SIG_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int OCW = $clog2(OUTQ_DEPTH+1);

  logic           q_valid;
  op_t            q_data;
  logic           q_pop;
  logic [OCW-1:0] out_count;
  logic           res_push;
  out_t           res_data;

  wbss_front #(
    .SIGNATURE_MAX (SIGNATURE_MAX)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  wbss_back #(
    .SIGNATURE_MAX (SIGNATURE_MAX)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_count (out_count),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  wbss_fifo #(
    .WIDTH ($bits(out_t)),
    .DEPTH (OUTQ_DEPTH)
  ) u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_data),
    .pop       (out_valid && out_ready),
    .pop_data  (out_data),
    .count     (out_count)
  );

  assign out_valid = (out_count != '0);

endmodule

@@ hw/rtl/wbss_checker.sv @@
// Port-level checks for the wildcard byte signature scanner, bound to the top level.
// Depends on wbss_pkg and wildcard_byte_signature_scanner_unit.
module wbss_checker
  import wbss_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  a_reset_out_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result beat presented right after reset.");

  a_reset_in_ready: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("Input not ready right after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Stalled result beat changed or dropped.");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |->
      (out_data.match_offset == '0) && (out_data.match_address == '0))
    else $error("Not found result carries a nonzero offset or address.");

endmodule

bind wildcard_byte_signature_scanner_unit wbss_checker u_wbss_checker (.*);
